[hw/rtl/arpcr_pkg.sv]
// Shared types and constants of the ARP cache and responder.
`default_nettype none

package arpcr_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Command queue between the front and the back.
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

	// ARP header values that a received packet must carry.
	localparam logic [10:0] MIN_ARP_LEN    = 11'd28;
	localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
	localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
	localparam logic [15:0] ARPOP_REQ      = 16'h0001;

	// Reset value of the local IP register (10.0.2.15).
	localparam logic [31:0] LOCAL_IP_RESET = 32'h0A00020F;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_IP  = 1'b0,
		REG_LOCAL_MAC = 1'b1
	} cfg_reg_t;

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_RX     = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_ADD    = 2'd2
	} op_t;

	// Command class decided by the front.
	typedef enum logic [1:0] {
		K_NOP,
		K_LEARN,
		K_LOOKUP,
		K_ADD
	} cmd_kind_t;

	// Input word.
	typedef struct packed {
		logic [1:0]  operation;
		logic [10:0] packet_length;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] arp_opcode;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [47:0] peer_mac;
		logic [31:0] query_ip;
	} in_t;

	// Result word.
	typedef struct packed {
		logic        accepted;
		logic        hit;
		logic [47:0] found_mac;
		logic        send_reply;
		logic [47:0] reply_dest_mac;
		logic [31:0] reply_dst_ip;
		logic [31:0] reply_src_ip;
	} res_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] key_ip;
		logic [47:0] mac;
		logic        send_reply;
		logic [31:0] reply_dst_ip;
		logic [31:0] reply_src_ip;
	} cmd_t;

	// One table entry.
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} ent_t;

endpackage

`default_nettype wire

[hw/rtl/arpcr_front.sv]
// Front part: configuration registers, packet validation and command classification.
`default_nettype none

module arpcr_front
	import arpcr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire in_t                  in_word,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [47:0]          cfg_data,
	input  wire logic                 cmdq_full,
	output logic                      cmdq_push,
	output cmd_t                      cmdq_data
);

	logic [31:0] local_ip_q;
	logic        pkt_ok;
	logic        is_request;

	// The register port never stalls.
	assign cfg_ready = 1'b1;

	// Register writes. The own MAC appears in no result word, so its write
	// is taken without storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= LOCAL_IP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOCAL_IP: begin
					local_ip_q <= cfg_data[31:0];
				end
				REG_LOCAL_MAC: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Header checks of a received packet.
	assign pkt_ok = (in_word.packet_length >= MIN_ARP_LEN)
		&& (in_word.hw_type == HW_TYPE_ETH)
		&& (in_word.proto_type == PROTO_IPV4)
		&& (in_word.hw_len == HW_ADDR_LEN)
		&& (in_word.proto_len == PROTO_ADDR_LEN);
	assign is_request = (in_word.arp_opcode == ARPOP_REQ)
		&& (in_word.dst_ip == local_ip_q);

	// Classify the word into a command for the back part.
	always_comb begin
		cmdq_data = '0;
		cmdq_data.kind = K_NOP;
		cmdq_data.mac  = in_word.peer_mac;
		unique case (in_word.operation)
			OP_RX: begin
				if (pkt_ok) begin
					cmdq_data.kind   = K_LEARN;
					cmdq_data.key_ip = in_word.src_ip;
					if (is_request) begin
						cmdq_data.send_reply   = 1'b1;
						cmdq_data.reply_dst_ip = in_word.src_ip;
						cmdq_data.reply_src_ip = local_ip_q;
					end
				end
			end
			OP_LOOKUP: begin
				cmdq_data.kind   = K_LOOKUP;
				cmdq_data.key_ip = in_word.query_ip;
			end
			OP_ADD: begin
				cmdq_data.kind   = K_ADD;
				cmdq_data.key_ip = in_word.query_ip;
			end
			default: begin
				cmdq_data.kind = K_NOP;
			end
		endcase
	end

	assign full      = cmdq_full;
	assign cmdq_push = push && !cmdq_full;

endmodule

`default_nettype wire

[hw/rtl/arpcr_cmdq.sv]
// Short command queue between the front and the back.
`default_nettype none

module arpcr_cmdq
	import arpcr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output logic      rd_valid,
	output cmd_t      rd_data
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full     = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/arpcr_back.sv]
// Back part: sequential table search, entry update and the result register.
`default_nettype none

module arpcr_back
	import arpcr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd_data,
	output logic      cmd_pop,
	output logic      empty,
	input  wire logic pop,
	output res_t      res_word
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	ent_t             rd_data_s1;
	logic             hit_q;
	logic [IDX_W-1:0] slot_q;
	logic [47:0]      mac_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ptr_q;
	res_t             res_q;
	logic             res_vld_q;

	ent_t             tbl_mem [TABLE_DEPTH];

	logic             issue;
	logic             match;
	logic             scan_done;
	logic             fin_go;
	logic             store;
	logic             tbl_full;
	logic [IDX_W-1:0] wr_addr;
	res_t             res_next;

	// Scan control: one read issued per cycle, compared in the cycle after.
	assign match     = rd_vld_s1 && (rd_data_s1.ip == cmd_q.key_ip);
	assign issue     = (state_q == S_SCAN) && !match && (rd_idx_q < cnt_q);
	assign scan_done = (state_q == S_SCAN) && !match && !rd_vld_s1
		&& (rd_idx_q == cnt_q);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;

	// Finishing step waits for a free result register.
	assign fin_go   = (state_q == S_FINISH) && (!res_vld_q || pop);
	assign store    = (cmd_q.kind == K_LEARN) || (cmd_q.kind == K_ADD);
	assign tbl_full = (cnt_q == CNT_W'(TABLE_DEPTH));

	// Slot to write: the matching entry, the next free one, or the victim.
	always_comb begin
		priority if (hit_q) begin
			wr_addr = slot_q;
		end else if (!tbl_full) begin
			wr_addr = cnt_q[IDX_W-1:0];
		end else begin
			wr_addr = ptr_q;
		end
	end

	// Result word of the current command.
	always_comb begin
		res_next                = '0;
		res_next.accepted       = (cmd_q.kind == K_LEARN);
		res_next.hit            = (cmd_q.kind == K_LOOKUP) && hit_q;
		res_next.found_mac      = res_next.hit ? mac_q : '0;
		res_next.send_reply     = cmd_q.send_reply;
		res_next.reply_dest_mac = cmd_q.send_reply ? cmd_q.mac : '0;
		res_next.reply_dst_ip   = cmd_q.reply_dst_ip;
		res_next.reply_src_ip   = cmd_q.reply_src_ip;
	end

	// Table memory: one registered read port, one write port.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= tbl_mem[rd_idx_q[IDX_W-1:0]];
		end
		if (fin_go && store) begin
			tbl_mem[wr_addr] <= '{ip: cmd_q.key_ip, mac: cmd_q.mac};
		end
	end

	// Sequencer, table bookkeeping and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			slot_q     <= '0;
			mac_q      <= '0;
			cnt_q      <= '0;
			ptr_q      <= '0;
			res_q      <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// A taken result frees the register unless a new one is loaded.
			if (pop && res_vld_q && !fin_go) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd_data;
						rd_idx_q <= '0;
						hit_q    <= 1'b0;
						state_q  <= (cmd_data.kind == K_NOP) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
						rd_idx_q   <= rd_idx_q + 1'b1;
					end
					if (match) begin
						hit_q   <= 1'b1;
						slot_q  <= cmp_idx_s1;
						mac_q   <= rd_data_s1.mac;
						state_q <= S_FINISH;
					end else if (scan_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						res_q     <= res_next;
						res_vld_q <= 1'b1;
						if (store && !hit_q) begin
							if (!tbl_full) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								ptr_q <= (ptr_q == IDX_W'(TABLE_DEPTH - 1)) ? '0
									: ptr_q + 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty    = !res_vld_q;
	assign res_word = res_q;

`ifndef ASSERT_OFF
	// The fill count never passes the table size.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("table fill count exceeds depth");

	// The replacement pointer only moves once the table is full.
	a_ptr_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q != $past(ptr_q)) |-> ($past(cnt_q) == CNT_W'(TABLE_DEPTH)))
		else $error("replacement pointer moved before table was full");

	// The scan never reads beyond the filled entries.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (rd_idx_q < cnt_q))
		else $error("table scan read an unfilled entry");

	// A new result appears only out of the finishing step.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> ($past(state_q) == S_FINISH))
		else $error("result loaded outside the finishing step");
`endif

endmodule

`default_nettype wire

[hw/rtl/arp_cache_and_responder_unit.sv]
// Top level of the ARP cache and responder.
//
//   channel   direction  handshake             word
//   input     in         push / full           in_word (in_t)
//   result    out        empty / pop           res_word (res_t)
//   register  in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A word whose IP is absent is taken as a command, then every filled entry is read in turn
// through the single table read port and compared; last, the table is updated for a learn or
// add and the result register is loaded. A hit ends the scan at the matching slot; with an
// empty table nothing is read. Invalid packets and unused operation codes skip the scan.
// Reset is asynchronous and active low; the table contents are not cleared, only
// the fill count and replacement pointer. A waiting result stalls only the back
// part: the front keeps accepting words into a two-entry command queue.
`default_nettype none

module arp_cache_and_responder_unit
	import arpcr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire in_t                  in_word,
	output logic                      empty,
	input  wire logic                 pop,
	output res_t                      res_word,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [47:0]          cfg_data
);

	logic cmdq_full;
	logic cmdq_push;
	cmd_t cmdq_wdata;
	logic cmdq_pop;
	logic cmdq_valid;
	cmd_t cmdq_rdata;

	// Validation and classification.
	arpcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmdq_full (cmdq_full),
		.cmdq_push (cmdq_push),
		.cmdq_data (cmdq_wdata)
	);

	// Decoupling queue.
	arpcr_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmdq_push),
		.wr_data  (cmdq_wdata),
		.full     (cmdq_full),
		.rd_en    (cmdq_pop),
		.rd_valid (cmdq_valid),
		.rd_data  (cmdq_rdata)
	);

	// Table search, update and result.
	arpcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmdq_valid),
		.cmd_data  (cmdq_rdata),
		.cmd_pop   (cmdq_pop),
		.empty     (empty),
		.pop       (pop),
		.res_word  (res_word)
	);

endmodule

`default_nettype wire

[sim/arp_cache_and_responder_unit_tb.sv]
// Self-checking testbench of the ARP cache and responder: directed and random words.
`timescale 1ns / 1ps

module arp_cache_and_responder_unit_tb;
	import arpcr_pkg::*;

	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [15:0] ARPOP_RSP    = 16'h0002;
	localparam logic [15:0] PROTO_IPV6   = 16'h86DD;
	localparam int POOL_SIZE  = 24;
	localparam int SETTLE     = 30;
	localparam int LONG_HOLD  = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_WORDS = 530;

	// Mirror of the ARP table that predicts every result word and checks it.
	class arp_scoreboard;
		logic [31:0] own_ip;
		logic [47:0] own_mac;
		logic [31:0] slot_ip [TABLE_DEPTH];
		logic [47:0] slot_mac [TABLE_DEPTH];
		int unsigned filled;
		int unsigned victim;
		res_t awaited[$];
		int unsigned mismatches, words_in, learned, rejected, replies, hits, replaced;

		function new();
			own_ip = LOCAL_IP_RESET;
			own_mac = '0;
			filled = 0;
			victim = 0;
			mismatches = 0;
			words_in = 0;
			learned = 0;
			rejected = 0;
			replies = 0;
			hits = 0;
			replaced = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [47:0] data);
			if (idx == REG_LOCAL_IP)
				own_ip = data[31:0];
			else
				own_mac = data;
		endfunction

		// First filled slot that holds the IP, or -1.
		function int find_ip(logic [31:0] ip);
			for (int i = 0; i < filled; i++)
				if (slot_ip[i] == ip)
					return i;
			return -1;
		endfunction

		// Refresh an existing mapping, else fill the next free slot, else evict round robin.
		function void learn(logic [31:0] ip, logic [47:0] mac);
			int slot;
			slot = find_ip(ip);
			if (slot >= 0) begin
				slot_mac[slot] = mac;
			end else if (filled < TABLE_DEPTH) begin
				slot_ip[filled] = ip;
				slot_mac[filled] = mac;
				filled++;
			end else begin
				slot_ip[victim] = ip;
				slot_mac[victim] = mac;
				victim = (victim + 1) % TABLE_DEPTH;
				replaced++;
			end
		endfunction

		// Work out the result of an accepted input word and queue it.
		function void note_word(in_t w);
			res_t r;
			int slot;
			r = '0;
			words_in++;
			case (w.operation)
				OP_RX: begin
					if (w.packet_length >= MIN_ARP_LEN && w.hw_type == HW_TYPE_ETH &&
					    w.proto_type == PROTO_IPV4 && w.hw_len == HW_ADDR_LEN &&
					    w.proto_len == PROTO_ADDR_LEN) begin
						learn(w.src_ip, w.peer_mac);
						r.accepted = 1'b1;
						learned++;
						if (w.arp_opcode == ARPOP_REQ && w.dst_ip == own_ip) begin
							r.send_reply = 1'b1;
							r.reply_dest_mac = w.peer_mac;
							r.reply_dst_ip = w.src_ip;
							r.reply_src_ip = own_ip;
							replies++;
						end
					end else begin
						rejected++;
					end
				end
				OP_LOOKUP: begin
					slot = find_ip(w.query_ip);
					if (slot >= 0) begin
						r.hit = 1'b1;
						r.found_mac = slot_mac[slot];
						hits++;
					end
				end
				OP_ADD: learn(w.query_ip, w.peer_mac);
				default: ;
			endcase
			awaited.push_back(r);
		endfunction

		function void compare_field(string field, logic [47:0] want, logic [47:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h, got %h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		// Compare a popped result word with the oldest prediction.
		function void check_word(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result word %h arrived with none expected", $time, got);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			compare_field("accepted", 48'(want.accepted), 48'(got.accepted));
			compare_field("hit", 48'(want.hit), 48'(got.hit));
			compare_field("found_mac", want.found_mac, got.found_mac);
			compare_field("send_reply", 48'(want.send_reply), 48'(got.send_reply));
			compare_field("reply_dest_mac", want.reply_dest_mac, got.reply_dest_mac);
			compare_field("reply_dst_ip", 48'(want.reply_dst_ip), 48'(got.reply_dst_ip));
			compare_field("reply_src_ip", 48'(want.reply_src_ip), 48'(got.reply_src_ip));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_t                  in_word;
	logic                 empty;
	logic                 pop;
	res_t                 res_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [47:0]          cfg_data;

	arp_scoreboard sb = new();
	int unsigned push_idle_pct = 0;
	int unsigned pop_idle_pct = 0;
	bit hold_off_req = 1'b0;
	int unsigned quiet_cycles = 0;
	logic [31:0] ip_pool [POOL_SIZE];

	arp_cache_and_responder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.empty(empty),
		.pop(pop),
		.res_word(res_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: pops at random, with an optional long hold-off.
	initial begin
		pop <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				pop <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off_req = 1'b0;
			end
			pop <= ($urandom_range(0, 99) >= pop_idle_pct);
		end
	end

	// Check every result word taken.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word(res_word);
	end

	// Watchdog on cycles in which no handshake completes.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
			         $time, STALL_LIMIT, sb.awaited.size());
			$display("[arp_cache_and_responder_unit] ERROR");
			$finish;
		end
	end

	// Offer one input word, idling each cycle at the set rate first; returns at a
	// falling edge.
	task automatic send_word(in_t w);
		while ($urandom_range(0, 99) < push_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (full);
		sb.note_word(w);
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has been taken.
	task automatic wait_idle();
		push <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write both registers back to back; the IP write carries junk in the upper bits.
	task automatic set_registers(logic [31:0] ip, logic [47:0] mac);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LOCAL_IP;
		cfg_data <= {16'($urandom), ip};
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(REG_LOCAL_IP, {16'h0, ip});
		@(negedge clk);
		cfg_index <= REG_LOCAL_MAC;
		cfg_data <= mac;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(REG_LOCAL_MAC, mac);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A well-formed ARP packet word.
	function automatic in_t arp_packet(logic [15:0] opcode, logic [31:0] sip, logic [31:0] tip,
	                                   logic [47:0] mac);
		in_t w;
		w = '0;
		w.operation = OP_RX;
		w.packet_length = MIN_ARP_LEN;
		w.hw_type = HW_TYPE_ETH;
		w.proto_type = PROTO_IPV4;
		w.hw_len = HW_ADDR_LEN;
		w.proto_len = PROTO_ADDR_LEN;
		w.arp_opcode = opcode;
		w.src_ip = sip;
		w.dst_ip = tip;
		w.peer_mac = mac;
		w.query_ip = $urandom;
		return w;
	endfunction

	function automatic in_t table_word(logic [1:0] op, logic [31:0] ip, logic [47:0] mac);
		in_t w;
		w = '0;
		w.operation = op;
		w.query_ip = ip;
		w.peer_mac = mac;
		return w;
	endfunction

	function automatic logic [47:0] rand_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Header checks, replies, duplicates and unused codes, under the reset register values.
	task automatic run_directed();
		in_t w;
		logic [31:0] ip_a, ip_b, ip_c, ip_d;
		logic [47:0] mac1, mac2, mac3;
		ip_a = $urandom;
		ip_b = $urandom;
		ip_c = $urandom;
		ip_d = $urandom;
		mac1 = rand_mac();
		mac2 = rand_mac();
		mac3 = rand_mac();
		send_word(arp_packet(ARPOP_REQ, ip_a, sb.own_ip, mac1));
		send_word(table_word(OP_LOOKUP, ip_a, '0));
		send_word(table_word(OP_LOOKUP, ip_b, '0));
		// Each header check failing on its own.
		w = arp_packet(ARPOP_REQ, ip_b, sb.own_ip, mac2);
		w.packet_length = MIN_ARP_LEN - 11'd1;
		send_word(w);
		w.packet_length = '0;
		send_word(w);
		w = arp_packet(ARPOP_REQ, ip_b, sb.own_ip, mac2);
		w.hw_type = '0;
		send_word(w);
		w = arp_packet(ARPOP_REQ, ip_b, sb.own_ip, mac2);
		w.proto_type = PROTO_IPV6;
		send_word(w);
		w = arp_packet(ARPOP_REQ, ip_b, sb.own_ip, mac2);
		w.hw_len = 8'hFF;
		send_word(w);
		w = arp_packet(ARPOP_REQ, ip_b, sb.own_ip, mac2);
		w.proto_len = '0;
		send_word(w);
		// A reply to us is learned but not answered; a request for someone else likewise.
		w = arp_packet(ARPOP_RSP, ip_b, sb.own_ip, '1);
		w.packet_length = 11'd1514;
		send_word(w);
		send_word(arp_packet(ARPOP_REQ, ip_c, sb.own_ip + 32'd1, mac3));
		// Adds, duplicate refresh through add and through a packet.
		send_word(table_word(OP_ADD, ip_d, '0));
		send_word(table_word(OP_ADD, ip_a, mac2));
		send_word(table_word(OP_LOOKUP, ip_a, '0));
		send_word(arp_packet(ARPOP_REQ, ip_a, sb.own_ip, mac3));
		send_word(table_word(OP_LOOKUP, ip_a, '0));
		// Unused operation with every bit set.
		w = '1;
		send_word(w);
		send_word(table_word(OP_LOOKUP, '1, '0));
		send_word(table_word(OP_ADD, '1, '1));
		send_word(table_word(OP_LOOKUP, '1, '0));
		send_word(table_word(OP_LOOKUP, ip_d, '0));
		w = arp_packet(16'hFFFF, ip_c, sb.own_ip, mac1);
		w.packet_length = '1;
		send_word(w);
		send_word(table_word(OP_LOOKUP, ip_c, '0));
	endtask

	// Random words over a fresh IP pool larger than the table, so slots get replaced.
	task automatic run_random(int unsigned count, bit pressure);
		in_t w;
		logic [255:0] noise;
		int unsigned pick;
		for (int i = 0; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		if (pressure)
			hold_off_req = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (pressure && n == count / 2)
				wait_idle();
			noise = {$urandom, $urandom, $urandom, $urandom,
			         $urandom, $urandom, $urandom, $urandom};
			w = noise[$bits(in_t)-1:0];
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				w = arp_packet(($urandom_range(0, 9) < 6) ? ARPOP_REQ : 16'($urandom),
				               ip_pool[$urandom_range(0, POOL_SIZE - 1)],
				               ($urandom_range(0, 1) == 0) ? sb.own_ip : 32'($urandom),
				               rand_mac());
				w.packet_length = 11'($urandom_range(MIN_ARP_LEN, 1514));
				if ($urandom_range(0, 99) < 15)
					w.src_ip = $urandom;
				// Some packets break one header rule, or carry an oversized length.
				if ($urandom_range(0, 99) < 15) begin
					case ($urandom_range(0, 5))
						0: w.packet_length = 11'($urandom_range(0, MIN_ARP_LEN - 1));
						1: w.hw_type = 16'($urandom);
						2: w.proto_type = 16'($urandom);
						3: w.hw_len = 8'($urandom);
						4: w.proto_len = 8'($urandom);
						default: w.packet_length = 11'($urandom_range(1515, 2047));
					endcase
				end
			end else if (pick < 95) begin
				w.operation = (pick < 75) ? OP_LOOKUP : OP_ADD;
				w.query_ip = ($urandom_range(0, 99) < 85) ?
				             ip_pool[$urandom_range(0, POOL_SIZE - 1)] : 32'($urandom);
			end else if (pick < 98) begin
				w.operation = OP_UNUSED;
			end
			send_word(w);
		end
		wait_idle();
	endtask

	// Reset, then the directed part and three random phases with different pacing.
	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		in_word <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_LOCAL_IP;
		cfg_data <= '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		pop_idle_pct = 30;
		run_directed();
		wait_idle();

		set_registers('1, '1);
		push_idle_pct = 31;
		pop_idle_pct = 88;
		run_random(PHASE_WORDS, 1'b0);

		set_registers('0, '0);
		push_idle_pct = 88;
		pop_idle_pct = 31;
		run_random(PHASE_WORDS, 1'b0);

		set_registers($urandom, rand_mac());
		push_idle_pct = 0;
		pop_idle_pct = 0;
		run_random(PHASE_WORDS, 1'b1);

		$display("Ran %0d words under four register settings and three pacing mixes.",
		         sb.words_in);
		$display("Packets learned %0d, rejected %0d, replies %0d, lookup hits %0d, evictions %0d.",
		         sb.learned, sb.rejected, sb.replies, sb.hits, sb.replaced);
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("[arp_cache_and_responder_unit] OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.awaited.size());
			$display("[arp_cache_and_responder_unit] ERROR");
		end
		$finish;
	end

endmodule
